[sv/mandelbrot_escape_iteration_macros.svh]
// Assertion helpers for the top module of the escape-time block.
`ifndef MANDELBROT_ESCAPE_ITERATION_MACROS_SVH
`define MANDELBROT_ESCAPE_ITERATION_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MEI_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MEI_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/mei_pkg.sv]
package mei_pkg;

    localparam int POINT_W   = 32;
    localparam int COUNT_W   = 12;
    localparam int LIMIT_W   = 8;
    localparam int MAG_W     = 37;
    localparam int CFG_IDX_W = 2;
    localparam int RING_DEPTH = 4;
    localparam int TAG_W     = 3;

    localparam logic [CFG_IDX_W-1:0] REG_ITERATION_CAP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_LIMIT  = 2'd1;

    localparam logic [COUNT_W-1:0] CAP_RESET   = 12'd2000;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd20;

    // Control state of one slot circulating in the iteration ring.
    typedef struct packed {
        logic               valid;
        logic               done;
        logic [TAG_W-1:0]   tag;
        logic [COUNT_W-1:0] count;
    } slot_ctrl_t;

endpackage

[sv/mandelbrot_escape_iteration.sv]
// Mandelbrot escape-time unit. Each request carries a point c in signed fixed
// point with FRACTION_BITS fraction bits; the result gives the number of
// z = z*z + c steps done before |z|^2 reached escape_limit or the count reached
// iteration_cap, and the saturated |z|^2 of the last z. Points circulate in a
// four-stage ring (magnitude, partial products, product sum, update); one
// pass round the ring is one step of a point, and up to four points are
// iterated at once, interleaved, so new requests are taken while earlier
// points still iterate. A new request is taken whenever an empty slot, or one
// whose finished point retires, passes the ring entry, and results leave in
// request order.
module mandelbrot_escape_iteration #(
    parameter int FRACTION_BITS = 26
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // point_real [31:0], point_imag [63:32]
    input  logic [63:0]                     s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // iteration_count [11:0], final_magnitude_sq [48:12], zero fill [55:49]
    output logic [55:0]                     m_tdata,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [mei_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mei_pkg::COUNT_W-1:0]     cfg_data
);

    `include "mandelbrot_escape_iteration_macros.svh"

    localparam int F  = FRACTION_BITS;
    localparam int MW = ((F + 8 > 31) ? F + 8 : 31) + 1;
    localparam int XW = MW + 1;
    localparam int PW = 2 * MW;
    localparam int PTW = mei_pkg::POINT_W;

    // Configuration registers.
    logic [mei_pkg::COUNT_W-1:0] cap_reg;
    logic [mei_pkg::LIMIT_W-1:0] limit_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg   <= mei_pkg::CAP_RESET;
            limit_reg <= mei_pkg::LIMIT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == mei_pkg::REG_ITERATION_CAP) begin
                cap_reg <= cfg_data;
            end else if (cfg_index == mei_pkg::REG_ESCAPE_LIMIT) begin
                limit_reg <= cfg_data[mei_pkg::LIMIT_W-1:0];
            end
        end
    end

    // Ring stage A: slot state at the ring entry.
    mei_pkg::slot_ctrl_t       a_ctrl_reg, a_ctrl_next;
    logic signed [PTW-1:0]     a_cr_reg, a_cr_next, a_ci_reg, a_ci_next;
    logic signed [XW-1:0]      a_x_reg, a_x_next, a_y_reg, a_y_next;
    logic [mei_pkg::MAG_W-1:0] a_mag_reg, a_mag_next;

    // Stages B, C, D carry the slot alongside the multipliers.
    mei_pkg::slot_ctrl_t       b_ctrl_reg, c_ctrl_reg, d_ctrl_reg;
    logic signed [PTW-1:0]     b_cr_reg, c_cr_reg, d_cr_reg;
    logic signed [PTW-1:0]     b_ci_reg, c_ci_reg, d_ci_reg;
    logic                      b_neg_reg, c_neg_reg, d_neg_reg;
    logic [mei_pkg::MAG_W-1:0] b_mag_reg, c_mag_reg, d_mag_reg;
    logic [MW-1:0]             b_ax_reg, b_ay_reg;

    logic [XW-1:0]             abs_x, abs_y;
    logic [PW-1:0]             prod_xx, prod_yy, prod_xy;

    mei_pkg::slot_ctrl_t       u_ctrl;
    logic signed [XW-1:0]      u_x, u_y;
    logic [mei_pkg::MAG_W-1:0] u_mag;

    logic                      retire, accept, slot_free;
    logic [mei_pkg::TAG_W-1:0] head_reg, tail_reg;
    logic                      m_valid_reg;
    logic [mei_pkg::COUNT_W-1:0] m_count_reg;
    logic [mei_pkg::MAG_W-1:0] m_mag_reg;

    // Stage A to B: magnitudes of x and y, and the sign of their product.
    assign abs_x = a_x_reg[XW-1] ? (~a_x_reg + 1'b1) : a_x_reg;
    assign abs_y = a_y_reg[XW-1] ? (~a_y_reg + 1'b1) : a_y_reg;

    always_ff @(posedge aclk) begin
        b_ax_reg  <= abs_x[MW-1:0];
        b_ay_reg  <= abs_y[MW-1:0];
        b_neg_reg <= a_x_reg[XW-1] ^ a_y_reg[XW-1];
        b_cr_reg  <= a_cr_reg;
        b_ci_reg  <= a_ci_reg;
        b_mag_reg <= a_mag_reg;
        c_neg_reg <= b_neg_reg;
        c_cr_reg  <= b_cr_reg;
        c_ci_reg  <= b_ci_reg;
        c_mag_reg <= b_mag_reg;
        d_neg_reg <= c_neg_reg;
        d_cr_reg  <= c_cr_reg;
        d_ci_reg  <= c_ci_reg;
        d_mag_reg <= c_mag_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_ctrl_reg <= '0;
            c_ctrl_reg <= '0;
            d_ctrl_reg <= '0;
        end else begin
            b_ctrl_reg <= a_ctrl_reg;
            c_ctrl_reg <= b_ctrl_reg;
            d_ctrl_reg <= c_ctrl_reg;
        end
    end

    // Stages B to D: the two squares and the cross product.
    mei_mul #(.MW(MW)) u_mul_xx (.aclk(aclk), .a(b_ax_reg), .b(b_ax_reg), .p(prod_xx));
    mei_mul #(.MW(MW)) u_mul_yy (.aclk(aclk), .a(b_ay_reg), .b(b_ay_reg), .p(prod_yy));
    mei_mul #(.MW(MW)) u_mul_xy (.aclk(aclk), .a(b_ax_reg), .b(b_ay_reg), .p(prod_xy));

    // Stage D back to A: escape test and next z.
    mei_update #(.F(F), .MW(MW), .XW(XW)) u_update (
        .ctrl_in  (d_ctrl_reg),
        .c_real   (d_cr_reg),
        .c_imag   (d_ci_reg),
        .neg_xy   (d_neg_reg),
        .prod_xx  (prod_xx),
        .prod_yy  (prod_yy),
        .prod_xy  (prod_xy),
        .mag_in   (d_mag_reg),
        .cap      (cap_reg),
        .limit    (limit_reg),
        .ctrl_out (u_ctrl),
        .x_out    (u_x),
        .y_out    (u_y),
        .mag_out  (u_mag)
    );

    // A finished slot leaves only when it holds the oldest point.
    assign retire    = u_ctrl.valid && u_ctrl.done && (u_ctrl.tag == head_reg)
                     && (!m_valid_reg || m_tready);
    assign slot_free = !u_ctrl.valid || retire;
    assign s_tready  = slot_free;
    assign accept    = s_tvalid && slot_free;

    // Ring entry: load a new point, empty a retired slot, or recirculate.
    always_comb begin
        a_ctrl_next = u_ctrl;
        a_cr_next   = d_cr_reg;
        a_ci_next   = d_ci_reg;
        a_x_next    = u_x;
        a_y_next    = u_y;
        a_mag_next  = u_mag;
        if (accept) begin
            a_ctrl_next.valid = 1'b1;
            a_ctrl_next.done  = 1'b0;
            a_ctrl_next.tag   = tail_reg;
            a_ctrl_next.count = '0;
            a_cr_next = s_tdata[PTW-1:0];
            a_ci_next = s_tdata[2*PTW-1:PTW];
            a_x_next  = '0;
            a_y_next  = '0;
        end else if (retire) begin
            a_ctrl_next.valid = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        a_cr_reg  <= a_cr_next;
        a_ci_reg  <= a_ci_next;
        a_x_reg   <= a_x_next;
        a_y_reg   <= a_y_next;
        a_mag_reg <= a_mag_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_ctrl_reg <= '0;
            head_reg   <= '0;
            tail_reg   <= '0;
        end else begin
            a_ctrl_reg <= a_ctrl_next;
            if (accept) begin
                tail_reg <= tail_reg + 1'b1;
            end
            if (retire) begin
                head_reg <= head_reg + 1'b1;
            end
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (retire) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (retire) begin
            m_count_reg <= u_ctrl.count;
            m_mag_reg   <= u_mag;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'b0000000, m_mag_reg, m_count_reg};

    // The ring never holds more points than it has slots.
    `MEI_ASSERT_SAME(a_ring_bound, aclk, aresetn, 1'b1,
        (tail_reg - head_reg) <= mei_pkg::TAG_W'(mei_pkg::RING_DEPTH),
        "more points in flight than ring slots")
    // A loaded point starts live at the ring entry.
    `MEI_ASSERT_NEXT(a_load_live, aclk, aresetn, accept,
        a_ctrl_reg.valid && !a_ctrl_reg.done && (a_ctrl_reg.count == '0),
        "accepted point not loaded into the ring")
    // A retired point is presented on the result channel.
    `MEI_ASSERT_NEXT(a_retire_out, aclk, aresetn, retire,
        m_valid_reg && (head_reg == $past(head_reg) + 1'b1),
        "retired point not presented")

endmodule

[sv/mei_mul.sv]
module mei_mul #(
    parameter int MW = 32
) (
    input  logic            aclk,
    input  logic [MW-1:0]   a,
    input  logic [MW-1:0]   b,
    output logic [2*MW-1:0] p
);

    localparam int H  = (MW + 1) / 2;
    localparam int HW = MW - H;

    logic [2*H-1:0]  ll_reg;
    logic [MW-1:0]   lh_reg;
    logic [MW-1:0]   hl_reg;
    logic [2*HW-1:0] hh_reg;
    logic [2*MW-1:0] p_reg;

    // First stage: four partial products of the half words.
    always_ff @(posedge aclk) begin
        ll_reg <= a[H-1:0] * b[H-1:0];
        lh_reg <= a[H-1:0] * b[MW-1:H];
        hl_reg <= a[MW-1:H] * b[H-1:0];
        hh_reg <= a[MW-1:H] * b[MW-1:H];
    end

    // Second stage: weight and add the partial products.
    always_ff @(posedge aclk) begin
        p_reg <= {{(2*MW-2*H){1'b0}}, ll_reg}
               + ({{MW{1'b0}}, lh_reg} << H)
               + ({{MW{1'b0}}, hl_reg} << H)
               + ({{(2*MW-2*HW){1'b0}}, hh_reg} << (2*H));
    end

    assign p = p_reg;

endmodule

[sv/mei_update.sv]
module mei_update #(
    parameter int F  = 26,
    parameter int MW = 35,
    parameter int XW = 36
) (
    input  mei_pkg::slot_ctrl_t                 ctrl_in,
    input  logic signed [mei_pkg::POINT_W-1:0]  c_real,
    input  logic signed [mei_pkg::POINT_W-1:0]  c_imag,
    input  logic                                neg_xy,
    input  logic [2*MW-1:0]                     prod_xx,
    input  logic [2*MW-1:0]                     prod_yy,
    input  logic [2*MW-1:0]                     prod_xy,
    input  logic [mei_pkg::MAG_W-1:0]           mag_in,
    input  logic [mei_pkg::COUNT_W-1:0]         cap,
    input  logic [mei_pkg::LIMIT_W-1:0]         limit,
    output mei_pkg::slot_ctrl_t                 ctrl_out,
    output logic signed [XW-1:0]                x_out,
    output logic signed [XW-1:0]                y_out,
    output logic [mei_pkg::MAG_W-1:0]           mag_out
);

    localparam int QW = 2*MW - F;
    localparam int SW = QW + 3;

    logic [QW-1:0]            xx;
    logic [QW-1:0]            yy;
    logic [QW:0]              two_xy;
    logic [QW:0]              mag;
    logic [QW:0]              bound;
    logic                     escape;
    logic [mei_pkg::MAG_W-1:0] mag_sat;
    logic [SW-1:0]            c_real_ext;
    logic [SW-1:0]            c_imag_ext;
    logic [SW-1:0]            txy_ext;
    logic [SW-1:0]            sum_x;
    logic [SW-1:0]            sum_y;

    // Truncate the products to the fixed point grid; 2xy keeps one more bit.
    assign xx     = prod_xx[2*MW-1:F];
    assign yy     = prod_yy[2*MW-1:F];
    assign two_xy = prod_xy[2*MW-1:F-1];
    assign mag    = {1'b0, xx} + {1'b0, yy};
    assign bound  = {{(QW+1-mei_pkg::LIMIT_W-F){1'b0}}, limit, {F{1'b0}}};
    assign escape = !(mag < bound) || (ctrl_in.count >= cap);
    assign mag_sat = (|mag[QW:mei_pkg::MAG_W]) ? {mei_pkg::MAG_W{1'b1}}
                                               : mag[mei_pkg::MAG_W-1:0];

    // Next z from the squared terms and c.
    assign c_real_ext = {{(SW-mei_pkg::POINT_W){c_real[mei_pkg::POINT_W-1]}}, c_real};
    assign c_imag_ext = {{(SW-mei_pkg::POINT_W){c_imag[mei_pkg::POINT_W-1]}}, c_imag};
    assign txy_ext    = {2'b00, two_xy};
    assign sum_x = {3'b000, xx} - {3'b000, yy} + c_real_ext;
    assign sum_y = (neg_xy ? (~txy_ext + 1'b1) : txy_ext) + c_imag_ext;

    // Finished or empty slots pass unchanged; live ones either finish or step.
    always_comb begin
        ctrl_out = ctrl_in;
        x_out    = sum_x[XW-1:0];
        y_out    = sum_y[XW-1:0];
        mag_out  = mag_in;
        if (ctrl_in.valid && !ctrl_in.done) begin
            if (escape) begin
                ctrl_out.done = 1'b1;
                mag_out       = mag_sat;
            end else begin
                ctrl_out.count = ctrl_in.count + 1'b1;
            end
        end
    end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

    localparam int FRAC        = 26;
    localparam int IDLE_LIMIT  = 100000;
    localparam int LONG_HOLD   = 3000;
    localparam int SETTLE      = 40;

    localparam logic [mei_pkg::CFG_IDX_W-1:0] REG_UNUSED_2 = 2'd2;
    localparam logic [mei_pkg::CFG_IDX_W-1:0] REG_UNUSED_3 = 2'd3;

    typedef struct packed {
        logic [mei_pkg::COUNT_W-1:0] count;
        logic [mei_pkg::MAG_W-1:0]   mag;
    } escape_result_t;

    logic aclk;
    logic aresetn;
    logic s_tvalid;
    logic s_tready;
    logic [63:0] s_tdata;
    logic m_tvalid;
    logic m_tready;
    logic [55:0] m_tdata;
    logic cfg_valid;
    logic cfg_ready;
    logic [mei_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [mei_pkg::COUNT_W-1:0] cfg_data;

    // Shadow copies of the configuration registers.
    logic [mei_pkg::COUNT_W-1:0] cap_shadow;
    logic [mei_pkg::LIMIT_W-1:0] limit_shadow;

    escape_result_t pending_results[$];
    int errors;
    int idle_cycles;
    int burst_left;
    bit hold_request;
    int hold_left;
    int stall_phase;
    bit stall_mode;

    mandelbrot_escape_iteration #(.FRACTION_BITS(FRAC)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Clock with an 8 ns period.
    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    // Escape-time iteration of one point at the current register values.
    function automatic escape_result_t escape_point(input logic signed [31:0] c_re,
                                                    input logic signed [31:0] c_im);
        logic signed [63:0] x;
        logic signed [63:0] y;
        logic signed [63:0] cr;
        logic signed [63:0] ci;
        logic [63:0] ax;
        logic [63:0] ay;
        logic [127:0] prod;
        logic [63:0] xx;
        logic [63:0] yy;
        logic [63:0] two_xy;
        logic [63:0] mag;
        logic [63:0] bound;
        int unsigned steps;
        bit negative;
        escape_result_t r;
        x = 0;
        y = 0;
        cr = c_re;
        ci = c_im;
        steps = 0;
        bound = {56'd0, limit_shadow} << FRAC;
        forever begin
            ax = x[63] ? -x : x;
            ay = y[63] ? -y : y;
            prod = {64'd0, ax} * {64'd0, ax};
            xx = prod[FRAC +: 64];
            prod = {64'd0, ay} * {64'd0, ay};
            yy = prod[FRAC +: 64];
            mag = xx + yy;
            if (!(mag < bound) || steps >= cap_shadow) break;
            prod = {64'd0, ax} * {64'd0, ay};
            two_xy = prod[FRAC-1 +: 64];
            negative = x[63] != y[63];
            x = $signed(xx) - $signed(yy) + cr;
            y = (negative ? -$signed(two_xy) : $signed(two_xy)) + ci;
            steps++;
        end
        if (mag > 64'h1F_FFFF_FFFF) mag = 64'h1F_FFFF_FFFF;
        r.count = steps[mei_pkg::COUNT_W-1:0];
        r.mag = mag[mei_pkg::MAG_W-1:0];
        return r;
    endfunction

    // Send one point request; the sender works in bursts with gaps between them.
    task automatic send_point(input logic [31:0] c_re, input logic [31:0] c_im);
        int gap;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata <= {c_im, c_re};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_results.push_back(escape_point(c_re, c_im));
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
    endtask

    // Wait until every expected result has arrived and the block has settled.
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // Write one configuration register.
    task automatic write_reg(input logic [mei_pkg::CFG_IDX_W-1:0] idx,
                             input logic [mei_pkg::COUNT_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (idx == mei_pkg::REG_ITERATION_CAP) cap_shadow = val;
        else if (idx == mei_pkg::REG_ESCAPE_LIMIT) limit_shadow = val[mei_pkg::LIMIT_W-1:0];
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // A point drawn mostly from the region around the set, sometimes anywhere.
    task automatic send_random_point();
        logic [31:0] re;
        logic [31:0] im;
        if ($urandom_range(0, 4) == 0) begin
            re = $urandom;
            im = $urandom;
        end else begin
            re = $urandom_range(0, 32'h0E00_0000) - 32'h0A00_0000;
            im = $urandom_range(0, 32'h0C00_0000) - 32'h0600_0000;
        end
        send_point(re, im);
    endtask

    task automatic test_reset_values();
        send_point(32'h0000_0000, 32'h0000_0000);
        send_point(32'h8000_0000, 32'h8000_0000);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_point(32'h8000_0000, 32'h0000_0000);
        send_point(32'h0000_0000, 32'h7FFF_FFFF);
        send_point(32'hF800_0000, 32'h0000_0000);
        drain_results();
    endtask

    task automatic test_zero_cap_and_limit();
        write_reg(mei_pkg::REG_ITERATION_CAP, 12'd0);
        send_point(32'h0000_0000, 32'h0000_0000);
        send_point(32'hFFFF_FFFF, 32'h0000_0001);
        drain_results();
        write_reg(mei_pkg::REG_ITERATION_CAP, 12'd50);
        write_reg(mei_pkg::REG_ESCAPE_LIMIT, 12'd0);
        send_point(32'h0000_0000, 32'h0000_0000);
        send_point(32'h0400_0000, 32'hFC00_0000);
        drain_results();
    endtask

    task automatic test_extreme_settings();
        write_reg(mei_pkg::REG_ITERATION_CAP, 12'd4095);
        write_reg(mei_pkg::REG_ESCAPE_LIMIT, 12'hFFF);
        // Huge magnitude saturates on the first step.
        send_point(32'h8000_0000, 32'h8000_0000);
        send_point(32'h7FFF_FFFF, 32'h8000_0000);
        send_point(32'hF800_0000, 32'h0000_0000);
        send_point(32'h0100_0000, 32'h0200_0000);
        drain_results();
        write_reg(mei_pkg::REG_ITERATION_CAP, 12'd1);
        write_reg(mei_pkg::REG_ESCAPE_LIMIT, 12'd1);
        send_point(32'h0000_0000, 32'h0000_0000);
        send_point(32'h7FFF_FFFF, 32'h0000_0000);
        drain_results();
    endtask

    task automatic test_unknown_index();
        write_reg(mei_pkg::REG_ITERATION_CAP, 12'd30);
        write_reg(mei_pkg::REG_ESCAPE_LIMIT, 12'd4);
        write_reg(REG_UNUSED_2, 12'hFFF);
        write_reg(REG_UNUSED_3, 12'h000);
        send_point(32'h0000_0000, 32'h0000_0000);
        send_point(32'hFD00_0000, 32'h0100_0000);
        drain_results();
    endtask

    task automatic test_random_points();
        int n;
        for (int phase = 0; phase < 6; phase++) begin
            write_reg(mei_pkg::REG_ITERATION_CAP,
                      mei_pkg::COUNT_W'($urandom_range(1, 80)));
            write_reg(mei_pkg::REG_ESCAPE_LIMIT,
                      {4'($urandom_range(0, 15)), 8'($urandom_range(1, 255))});
            n = $urandom_range(35, 50);
            repeat (n) send_random_point();
            drain_results();
        end
    endtask

    task automatic test_backpressure();
        write_reg(mei_pkg::REG_ITERATION_CAP, 12'd20);
        write_reg(mei_pkg::REG_ESCAPE_LIMIT, 12'd4);
        hold_request = 1'b1;
        repeat (16) send_random_point();
        drain_results();
    endtask

    // Receiver: long hold-offs on request, otherwise stretches of full speed
    // alternating with random stalls.
    always @(negedge aclk) begin
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            stall_phase++;
            if (stall_phase >= 64) begin
                stall_phase = 0;
                stall_mode = ($urandom_range(0, 1) == 1);
            end
            m_tready <= stall_mode ? ($urandom_range(0, 2) != 0) : 1'b1;
        end
    end

    // Compare each result with the oldest expectation.
    always @(posedge aclk) begin
        escape_result_t want;
        escape_result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.count = m_tdata[11:0];
            got.mag = m_tdata[48:12];
            if (pending_results.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result count=%0d mag=%h",
                                           got.count, got.mag);
            end else begin
                want = pending_results.pop_front();
                if (got.count !== want.count || got.mag !== want.mag) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: count exp %0d got %0d, mag exp %h got %h",
                                 want.count, got.count, want.mag, got.mag);
                end
            end
        end
    end

    // Watchdog on cycles with no accepted request on any channel.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        errors = 0;
        idle_cycles = 0;
        burst_left = 0;
        hold_request = 1'b0;
        hold_left = 0;
        stall_phase = 0;
        stall_mode = 1'b0;
        cap_shadow = mei_pkg::CAP_RESET;
        limit_shadow = mei_pkg::LIMIT_RESET;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        repeat (4) @(posedge aclk);

        test_reset_values();
        test_zero_cap_and_limit();
        test_extreme_settings();
        test_unknown_index();
        test_random_points();
        test_backpressure();

        if (errors == 0 && pending_results.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+sv
sv/mei_pkg.sv
sv/mei_mul.sv
sv/mei_update.sv
sv/mandelbrot_escape_iteration.sv
tb/sv/tb_top.sv
